// ===== src/pointer_cursor_gesture_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker: assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef POINTER_CURSOR_GESTURE_TRACKER_DEFINES_SVH
`define POINTER_CURSOR_GESTURE_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCGT_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCGT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pcgt_pkg.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker package
// Shared constants, codes and the configuration register type.
// ----------------------------------------------------------------------------
`default_nettype none

package pcgt_pkg;

	// Default sizes for the top-level parameters
	localparam int COORD_BITS_DEF = 12;
	localparam int AGE_BITS_DEF   = 16;
	// Press age never grows past this many bits
	localparam int AGE_STATE_BITS = 16;

	// Register reset values
	localparam int RST_WIDTH  = 1280;
	localparam int RST_HEIGHT = 800;
	localparam int RST_MARGIN = 20;
	localparam int RST_HOLD   = 1;
	localparam int RST_DRAG   = 100;
	localparam int RST_XOFF   = 128;

	// Adjusted x saturation bounds
	localparam int ADJ_MAX = 4095;
	localparam int ADJ_MIN = -4096;

	// Port widths
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int IN_TDATA_BITS  = 24;
	localparam int IN_TUSER_BITS  = 2;
	localparam int OUT_TDATA_BITS = 48;

	// Result field positions in m_axis_tdata
	localparam int OUT_LEFT_BIT = 37;
	localparam int OUT_GEST_LSB = 40;

	// Command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_MOVE_X = 2'd0;
	localparam cmd_t CMD_MOVE_Y = 2'd1;
	localparam cmd_t CMD_BUTTON = 2'd2;
	localparam cmd_t CMD_TICK   = 2'd3;

	// Button ids
	typedef logic [1:0] btn_t;
	localparam btn_t BID_LEFT   = 2'd0;
	localparam btn_t BID_RIGHT  = 2'd1;
	localparam btn_t BID_MIDDLE = 2'd2;
	localparam btn_t BID_UNUSED = 2'd3;

	// Left gesture codes
	typedef logic [1:0] gest_t;
	localparam gest_t GEST_NONE  = 2'd0;
	localparam gest_t GEST_CLICK = 2'd1;
	localparam gest_t GEST_HOLD  = 2'd2;
	localparam gest_t GEST_DRAG  = 2'd3;

	// Register indexes
	typedef logic [CFG_IDX_BITS-1:0] reg_idx_t;
	localparam reg_idx_t REG_DISP_WIDTH   = 3'd0;
	localparam reg_idx_t REG_DISP_HEIGHT  = 3'd1;
	localparam reg_idx_t REG_EDGE_MARGIN  = 3'd2;
	localparam reg_idx_t REG_HOLD_TICKS   = 3'd3;
	localparam reg_idx_t REG_DRAG_DIST_SQ = 3'd4;
	localparam reg_idx_t REG_X_OFFSET     = 3'd5;

	typedef struct packed {
		logic [11:0] disp_width;
		logic [11:0] disp_height;
		logic [7:0]  edge_margin;
		logic [15:0] hold_ticks;
		logic [23:0] drag_dist_sq;
		logic [11:0] cursor_x_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		disp_width:      12'(RST_WIDTH),
		disp_height:     12'(RST_HEIGHT),
		edge_margin:     8'(RST_MARGIN),
		hold_ticks:      16'(RST_HOLD),
		drag_dist_sq:    24'(RST_DRAG),
		cursor_x_offset: 12'(RST_XOFF)
	};

endpackage

`default_nettype wire

// ===== src/pointer_cursor_gesture_tracker.sv =====
// Path: an input transfer passes the event register, the state update, the square
// stage and the result register before its result is presented.
// Throughput: one event per cycle; each stage moves on when the next has room.
// Reset: arst_n clears all valids, centers the cursor on the default screen,
// releases the buttons, clears the press record and loads register defaults.
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker
// Cursor position, button state and left gesture from pointer events.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_cursor_gesture_tracker #(
	parameter int COORD_BITS = pcgt_pkg::COORD_BITS_DEF,
	parameter int AGE_BITS   = pcgt_pkg::AGE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// event stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] delta, [17:16] button_id, [18] pressed, [23:19] zero
	input  logic [pcgt_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	// [1:0] cmd
	input  logic [pcgt_pkg::IN_TUSER_BITS-1:0]   s_axis_tuser,
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [11:0] cursor_x, [23:12] cursor_y, [36:24] adjusted_x, [37] left_down,
	// [38] right_down, [39] middle_down, [41:40] left_gesture, [47:42] zero
	output logic [pcgt_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pcgt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [pcgt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import pcgt_pkg::*;

	cfg_t cfg;

	logic                      snap_valid;
	logic                      snap_ready;
	logic [COORD_BITS-1:0]     snap_pos_x, snap_pos_y, snap_press_x, snap_press_y;
	logic [AGE_STATE_BITS-1:0] snap_age;
	logic [2:0]                snap_buttons;

	logic [11:0]        res_cursor_x, res_cursor_y;
	logic signed [12:0] res_adjusted_x;
	logic [2:0]         res_buttons;
	gest_t              res_gesture;

	pcgt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcgt_state #(
		.COORD_BITS (COORD_BITS),
		.AGE_BITS   (AGE_BITS)
	) u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_cmd       (s_axis_tuser[1:0]),
		.in_delta     (s_axis_tdata[15:0]),
		.in_button_id (s_axis_tdata[17:16]),
		.in_pressed   (s_axis_tdata[18]),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap_pos_x   (snap_pos_x),
		.snap_pos_y   (snap_pos_y),
		.snap_press_x (snap_press_x),
		.snap_press_y (snap_press_y),
		.snap_age     (snap_age),
		.snap_buttons (snap_buttons)
	);

	pcgt_classify #(
		.COORD_BITS (COORD_BITS)
	) u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.snap_valid     (snap_valid),
		.snap_ready     (snap_ready),
		.snap_pos_x     (snap_pos_x),
		.snap_pos_y     (snap_pos_y),
		.snap_press_x   (snap_press_x),
		.snap_press_y   (snap_press_y),
		.snap_age       (snap_age),
		.snap_buttons   (snap_buttons),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_cursor_x   (res_cursor_x),
		.out_cursor_y   (res_cursor_y),
		.out_adjusted_x (res_adjusted_x),
		.out_buttons    (res_buttons),
		.out_gesture    (res_gesture)
	);

	// Result packing, most significant field first
	assign m_axis_tdata = {6'b0, res_gesture, res_buttons, res_adjusted_x,
		res_cursor_y, res_cursor_x};

endmodule

`default_nettype wire

// ===== src/pcgt_cfg.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker: configuration registers
// Holds the six control registers written through the cfg channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcgt_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pcgt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [pcgt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output pcgt_pkg::cfg_t                       cfg
);
	import pcgt_pkg::*;

	cfg_t cfg_q;

	// Writes are always accepted
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register write on each transfer; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DISP_WIDTH:   cfg_q.disp_width      <= cfg_data[11:0];
				REG_DISP_HEIGHT:  cfg_q.disp_height     <= cfg_data[11:0];
				REG_EDGE_MARGIN:  cfg_q.edge_margin     <= cfg_data[7:0];
				REG_HOLD_TICKS:   cfg_q.hold_ticks      <= cfg_data[15:0];
				REG_DRAG_DIST_SQ: cfg_q.drag_dist_sq    <= cfg_data[23:0];
				REG_X_OFFSET:     cfg_q.cursor_x_offset <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/pcgt_state.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker: event register and tracker state
// Registers each event, applies it to position, buttons and press age,
// and passes a snapshot of the new state to the classify stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pcgt_state #(
	parameter int COORD_BITS = pcgt_pkg::COORD_BITS_DEF,
	parameter int AGE_BITS   = pcgt_pkg::AGE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcgt_pkg::cfg_t                       cfg,
	// event side
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  pcgt_pkg::cmd_t                       in_cmd,
	input  logic signed [15:0]                   in_delta,
	input  pcgt_pkg::btn_t                       in_button_id,
	input  logic                                 in_pressed,
	// snapshot side
	output logic                                 snap_valid,
	input  logic                                 snap_ready,
	output logic [COORD_BITS-1:0]                snap_pos_x,
	output logic [COORD_BITS-1:0]                snap_pos_y,
	output logic [COORD_BITS-1:0]                snap_press_x,
	output logic [COORD_BITS-1:0]                snap_press_y,
	output logic [pcgt_pkg::AGE_STATE_BITS-1:0]  snap_age,
	output logic [2:0]                           snap_buttons
);
	import pcgt_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int NW = ((CB > 16) ? CB : 16) + 2;
	localparam int AW = (AGE_BITS < AGE_STATE_BITS) ? AGE_BITS : AGE_STATE_BITS;
	localparam logic [CB-1:0] CMAX      = {CB{1'b1}};
	localparam logic [AW-1:0] AGE_SAT   = {AW{1'b1}};
	localparam logic [CB-1:0] POS_X_RST = CB'(RST_WIDTH / 2);
	localparam logic [CB-1:0] POS_Y_RST = CB'(RST_HEIGHT / 2);

	// Add a delta, then bound by margin below and size minus margin above (kept in 0..CMAX)
	function automatic logic [CB-1:0] clamp_move(
		input logic [CB-1:0]     pos,
		input logic signed [15:0] d,
		input logic [11:0]       size,
		input logic [7:0]        margin
	);
		logic signed [NW-1:0] n;
		logic signed [NW-1:0] lo;
		logic signed [NW-1:0] hi;
		n  = $signed(NW'(pos)) + NW'(d);
		lo = $signed(NW'(margin));
		hi = $signed(NW'(size)) - lo;
		if (hi < $signed(NW'(0)))
			hi = '0;
		if (hi > $signed(NW'(CMAX)))
			hi = $signed(NW'(CMAX));
		if (n < lo)
			n = lo;
		if (n > hi)
			n = hi;
		return n[CB-1:0];
	endfunction

	// Event register (s1)
	logic        v_s1;
	cmd_t        cmd_s1;
	logic signed [15:0] delta_s1;
	btn_t        bid_s1;
	logic        prs_s1;

	// Tracker state
	logic [CB-1:0] pos_x_q, pos_y_q, press_x_q, press_y_q;
	logic [AW-1:0] age_q;
	logic [2:0]    buttons_q;

	logic [CB-1:0] pos_x_d, pos_y_d, press_x_d, press_y_d;
	logic [AW-1:0] age_d;
	logic [2:0]    buttons_d;

	// Snapshot register (s2)
	logic          v_s2;
	logic [CB-1:0] pos_x_s2, pos_y_s2, press_x_s2, press_y_s2;
	logic [AW-1:0] age_s2;
	logic [2:0]    buttons_s2;

	logic s2_ready;
	logic advance;

	assign s2_ready = !v_s2 || snap_ready;
	assign in_ready = !v_s1 || s2_ready;
	assign advance  = v_s1 && s2_ready;

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= in_cmd;
			delta_s1 <= in_delta;
			bid_s1   <= in_button_id;
			prs_s1   <= in_pressed;
		end
	end

	// Next state from the registered event
	always_comb begin
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		press_x_d = press_x_q;
		press_y_d = press_y_q;
		age_d     = age_q;
		buttons_d = buttons_q;
		unique case (cmd_s1)
			CMD_MOVE_X: begin
				pos_x_d = clamp_move(pos_x_q, delta_s1, cfg.disp_width, cfg.edge_margin);
			end
			CMD_MOVE_Y: begin
				pos_y_d = clamp_move(pos_y_q, delta_s1, cfg.disp_height, cfg.edge_margin);
			end
			CMD_BUTTON: begin
				if (bid_s1 != BID_UNUSED) begin
					buttons_d[bid_s1] = prs_s1;
					// a left press (also a repeated one) restarts the press record
					if (bid_s1 == BID_LEFT && prs_s1) begin
						press_x_d = pos_x_q;
						press_y_d = pos_y_q;
						age_d     = '0;
					end
				end
			end
			CMD_TICK: begin
				if (age_q != AGE_SAT)
					age_d = age_q + AW'(1);
			end
			default: ;
		endcase
	end

	// State update as the event leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= POS_X_RST;
			pos_y_q   <= POS_Y_RST;
			press_x_q <= '0;
			press_y_q <= '0;
			age_q     <= '0;
			buttons_q <= '0;
		end else if (advance) begin
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			press_x_q <= press_x_d;
			press_y_q <= press_y_d;
			age_q     <= age_d;
			buttons_q <= buttons_d;
		end
	end

	// Snapshot stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_x_s2   <= pos_x_d;
			pos_y_s2   <= pos_y_d;
			press_x_s2 <= press_x_d;
			press_y_s2 <= press_y_d;
			age_s2     <= age_d;
			buttons_s2 <= buttons_d;
		end
	end

	assign snap_valid   = v_s2;
	assign snap_pos_x   = pos_x_s2;
	assign snap_pos_y   = pos_y_s2;
	assign snap_press_x = press_x_s2;
	assign snap_press_y = press_y_s2;
	assign snap_age     = AGE_STATE_BITS'(age_s2);
	assign snap_buttons = buttons_s2;

endmodule

`default_nettype wire

// ===== src/pcgt_classify.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker: gesture classify and result register
// Squares the distance from the press point, then classifies the left
// gesture and forms the adjusted x in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcgt_classify #(
	parameter int COORD_BITS = pcgt_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcgt_pkg::cfg_t                       cfg,
	// snapshot side
	input  logic                                 snap_valid,
	output logic                                 snap_ready,
	input  logic [COORD_BITS-1:0]                snap_pos_x,
	input  logic [COORD_BITS-1:0]                snap_pos_y,
	input  logic [COORD_BITS-1:0]                snap_press_x,
	input  logic [COORD_BITS-1:0]                snap_press_y,
	input  logic [pcgt_pkg::AGE_STATE_BITS-1:0]  snap_age,
	input  logic [2:0]                           snap_buttons,
	// result side
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [11:0]                          out_cursor_x,
	output logic [11:0]                          out_cursor_y,
	output logic signed [12:0]                   out_adjusted_x,
	output logic [2:0]                           out_buttons,
	output pcgt_pkg::gest_t                      out_gesture
);
	import pcgt_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int SQW = 2 * CB + 2;
	localparam int DW  = ((2 * CB + 3) > 24) ? (2 * CB + 3) : 24;
	localparam int AJW = ((CB > 12) ? CB : 12) + 3;
	localparam logic signed [AJW-1:0] ADJ_HI = AJW'(ADJ_MAX);
	localparam logic signed [AJW-1:0] ADJ_LO = AJW'(ADJ_MIN);

	// Square stage (s3)
	logic           v_s3;
	logic [CB-1:0]  pos_x_s3, pos_y_s3;
	logic [SQW-1:0] sqx_s3, sqy_s3;
	logic           early_s3;
	logic [2:0]     buttons_s3;

	logic signed [CB:0]    dx, dy;
	logic signed [SQW-1:0] sqx, sqy;

	// Result register
	logic        v_q;
	logic [11:0] cursor_x_q, cursor_y_q;
	logic signed [12:0] adj_q;
	logic [2:0]  buttons_q;
	gest_t       gest_q;

	logic [DW-1:0]          d2;
	logic signed [AJW-1:0]  adj_full;
	logic signed [12:0]     adj_d;
	gest_t                  gest_d;

	logic out_slot_ready;
	logic s3_ready;

	assign out_slot_ready = !v_q || out_ready;
	assign s3_ready       = !v_s3 || out_slot_ready;
	assign snap_ready     = s3_ready;

	// Offsets from the press point and their squares
	assign dx  = $signed({1'b0, snap_pos_x}) - $signed({1'b0, snap_press_x});
	assign dy  = $signed({1'b0, snap_pos_y}) - $signed({1'b0, snap_press_y});
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_ready) begin
			v_s3 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && s3_ready) begin
			pos_x_s3   <= snap_pos_x;
			pos_y_s3   <= snap_pos_y;
			sqx_s3     <= $unsigned(sqx);
			sqy_s3     <= $unsigned(sqy);
			early_s3   <= snap_age < cfg.hold_ticks;
			buttons_s3 <= snap_buttons;
		end
	end

	// Gesture: none with left up; a short press is a click, a long press is hold or drag
	assign d2 = DW'(sqx_s3) + DW'(sqy_s3);

	always_comb begin
		priority if (!buttons_s3[BID_LEFT])
			gest_d = GEST_NONE;
		else if (early_s3)
			gest_d = GEST_CLICK;
		else if (d2 > DW'(cfg.drag_dist_sq))
			gest_d = GEST_DRAG;
		else
			gest_d = GEST_HOLD;
	end

	// Adjusted x, saturated to the 13-bit signed range
	assign adj_full = $signed(AJW'(pos_x_s3)) + $signed(AJW'(cfg.edge_margin))
		- $signed(AJW'(cfg.cursor_x_offset));

	always_comb begin
		priority if (adj_full > ADJ_HI)
			adj_d = 13'(ADJ_HI);
		else if (adj_full < ADJ_LO)
			adj_d = 13'(ADJ_LO);
		else
			adj_d = adj_full[12:0];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (out_slot_ready) begin
			v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && out_slot_ready) begin
			cursor_x_q <= 12'(pos_x_s3);
			cursor_y_q <= 12'(pos_y_s3);
			adj_q      <= adj_d;
			buttons_q  <= buttons_s3;
			gest_q     <= gest_d;
		end
	end

	assign out_valid      = v_q;
	assign out_cursor_x   = cursor_x_q;
	assign out_cursor_y   = cursor_y_q;
	assign out_adjusted_x = adj_q;
	assign out_buttons    = buttons_q;
	assign out_gesture    = gest_q;

endmodule

`default_nettype wire

// ===== src/pcgt_checker.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker: port checker
// Watches the top-level ports for result and flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pointer_cursor_gesture_tracker_defines.svh"

module pcgt_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [pcgt_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
	import pcgt_pkg::*;

	// A left gesture is only reported while the left button is down
	`PCGT_ASSERT_SAME(a_gesture_needs_left, clk, arst_n, m_axis_tvalid, m_axis_tdata[OUT_LEFT_BIT] || m_axis_tdata[OUT_GEST_LSB +: 2] == GEST_NONE, "gesture reported with left button up")

	// With the result slot empty, nothing upstream may stall
	`PCGT_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled while result slot empty")

	// A stalled result stays offered
	`PCGT_ASSERT_NEXT(a_out_valid_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn under stall")

	// A stalled result keeps its data
	`PCGT_ASSERT_NEXT(a_out_data_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed under stall")

endmodule

bind pointer_cursor_gesture_tracker pcgt_checker u_pcgt_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor gesture tracker testbench
// Feeds motion, button and tick events through the event stream and writes
// the screen registers between phases. A behavioral tracker in this file
// predicts every report, and each report that leaves the block is compared
// field by field with the oldest prediction. Directed cases cover the clamp
// extremes, every button and the gestures. The edge settings and the press
// age threshold follow, then random gesture sequences and noise under random
// stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import pcgt_pkg::*;

	localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
	localparam int WDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS = 40;
	localparam int DRAIN_WAIT  = 6;

	// One report, laid out as on m_axis_tdata (msb first)
	typedef struct packed {
		logic [5:0]  pad;
		gest_t       gesture;
		logic        middle;
		logic        right;
		logic        left;
		logic [12:0] adj_x;
		logic [11:0] cy;
		logic [11:0] cx;
	} cursor_report_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_BITS-1:0] s_axis_tdata;
	logic [IN_TUSER_BITS-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// Tracker state
	cfg_t        active_cfg;
	logic [11:0] cur_x, cur_y, press_x, press_y;
	logic [15:0] press_age;
	logic [2:0]  btn_state;

	cursor_report_t pending_reports[$];
	cursor_report_t want_report, got_report;
	int  errors;
	int  counted_events;
	int  quiet_cycles;
	bit  idle_on;

	pointer_cursor_gesture_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Add a delta, then apply the low bound and the high bound in that order
	function automatic logic [11:0] clamp_axis(logic [11:0] pos, logic signed [15:0] d,
			logic [11:0] size);
		int lo, hi, n;
		lo = int'(active_cfg.edge_margin);
		hi = int'(size) - lo;
		if (hi < 0) hi = 0;
		if (hi > COORD_MAX) hi = COORD_MAX;
		n = int'(pos) + int'(d);
		if (n < lo) n = lo;
		if (n > hi) n = hi;
		return n[11:0];
	endfunction

	// Advance the tracker by one event and return the report it produces
	function automatic cursor_report_t track_event(cmd_t c, logic [15:0] d, btn_t b,
			logic p);
		cursor_report_t r;
		longint dx, dy;
		int adj;
		r = '0;
		case (c)
			CMD_MOVE_X: cur_x = clamp_axis(cur_x, d, active_cfg.disp_width);
			CMD_MOVE_Y: cur_y = clamp_axis(cur_y, d, active_cfg.disp_height);
			CMD_BUTTON: begin
				if (b != BID_UNUSED) begin
					btn_state[b] = p;
					if (b == BID_LEFT && p) begin
						press_x   = cur_x;
						press_y   = cur_y;
						press_age = '0;
					end
				end
			end
			default: if (press_age != 16'hFFFF) press_age = press_age + 16'd1;
		endcase
		r.gesture = GEST_NONE;
		if (btn_state[BID_LEFT]) begin
			if (press_age < active_cfg.hold_ticks) begin
				r.gesture = GEST_CLICK;
			end else begin
				dx = longint'(cur_x) - longint'(press_x);
				dy = longint'(cur_y) - longint'(press_y);
				r.gesture = (dx * dx + dy * dy > longint'(active_cfg.drag_dist_sq)) ?
					GEST_DRAG : GEST_HOLD;
			end
		end
		adj = int'(cur_x) + int'(active_cfg.edge_margin) - int'(active_cfg.cursor_x_offset);
		if (adj > ADJ_MAX) adj = ADJ_MAX;
		if (adj < ADJ_MIN) adj = ADJ_MIN;
		r.cx     = cur_x;
		r.cy     = cur_y;
		r.adj_x  = adj[12:0];
		r.left   = btn_state[BID_LEFT];
		r.right  = btn_state[BID_RIGHT];
		r.middle = btn_state[BID_MIDDLE];
		return r;
	endfunction

	// One event transfer; starts and ends just after a falling edge
	task automatic send_event(cmd_t c, logic [15:0] d, btn_t b, logic p);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = c;
		s_axis_tdata  = {5'b0, p, b, d};
		do @(posedge clk); while (!s_axis_tready);
		pending_reports.push_back(track_event(c, d, b, p));
		if (!(c == CMD_BUTTON && b == BID_UNUSED)) counted_events++;
		@(negedge clk);
	endtask

	// Hold the sender until every report is back and the pipeline is empty
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Write all six registers while the block is idle
	task automatic apply_cfg(cfg_t c);
		wait_drained();
		write_reg(REG_DISP_WIDTH,   24'(c.disp_width));
		write_reg(REG_DISP_HEIGHT,  24'(c.disp_height));
		write_reg(REG_EDGE_MARGIN,  24'(c.edge_margin));
		write_reg(REG_HOLD_TICKS,   24'(c.hold_ticks));
		write_reg(REG_DRAG_DIST_SQ, 24'(c.drag_dist_sq));
		write_reg(REG_X_OFFSET,     24'(c.cursor_x_offset));
		cfg_valid = 1'b0;
		active_cfg = c;
	endtask

	function automatic logic [15:0] rand_delta();
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return 16'(int'($urandom_range(0, 80)) - 40);
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.disp_width    = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(64, 300)) :
			12'($urandom_range(64, 4095));
		c.disp_height   = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(64, 300)) :
			12'($urandom_range(64, 4095));
		c.edge_margin   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40)) :
			8'($urandom);
		c.hold_ticks    = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
			16'($urandom_range(1, 12));
		c.drag_dist_sq  = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
			24'($urandom_range(0, 3000));
		c.cursor_x_offset = 12'($urandom);
		return c;
	endfunction

	// Reset values, extremes of delta, every button and the gesture sequence
	task automatic test_directed();
		send_event(CMD_TICK,   16'h0000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'h8000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'h8000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'h0000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'd100,  BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'hFFFF, BID_RIGHT,  1'b1);
		send_event(CMD_BUTTON, 16'h0000, BID_MIDDLE, 1'b1);
		send_event(CMD_BUTTON, 16'h0000, BID_UNUSED, 1'b1);
		// click, then a second press re-records the position
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b1);
		send_event(CMD_MOVE_X, 16'd3,    BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b1);
		// hold, still hold at distance 25, drag past 100
		send_event(CMD_TICK,   16'h0000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'd5,    BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'd6,    BID_LEFT, 1'b0);
		// right and middle must not touch the left timer
		send_event(CMD_BUTTON, 16'h0000, BID_RIGHT,  1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_MIDDLE, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_UNUSED, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT,   1'b0);
		send_event(CMD_TICK,   16'h0000, BID_LEFT,   1'b0);
	endtask

	// Tiny screen with no room, huge screen, margin change after the move
	task automatic test_config_edges();
		cfg_t c;
		c = '{disp_width: 12'd64, disp_height: 12'd64, edge_margin: 8'd255,
			hold_ticks: 16'd0, drag_dist_sq: 24'd0, cursor_x_offset: 12'hFFF};
		apply_cfg(c);
		send_event(CMD_TICK,   16'h0000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'd1,    BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'h8000, BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b1);
		send_event(CMD_MOVE_X, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b0);

		c = '{disp_width: 12'hFFF, disp_height: 12'hFFF, edge_margin: 8'd0,
			hold_ticks: 16'hFFFF, drag_dist_sq: 24'hFFFFFF, cursor_x_offset: 12'd0};
		apply_cfg(c);
		send_event(CMD_MOVE_X, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b1);

		// the cursor stays put until the next move, so adjusted x saturates
		c.edge_margin = 8'd255;
		apply_cfg(c);
		send_event(CMD_TICK,   16'h0000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_X, 16'h8000, BID_LEFT, 1'b0);
	endtask

	// Press age crosses a long hold threshold: click up to it, then hold, then drag
	task automatic test_press_age();
		cfg_t c;
		c = '{disp_width: 12'hFFF, disp_height: 12'hFFF, edge_margin: 8'd0,
			hold_ticks: 16'd40, drag_dist_sq: 24'hFFFFFF, cursor_x_offset: 12'd64};
		apply_cfg(c);
		idle_on = 1'b0;
		send_event(CMD_MOVE_X, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'h7FFF, BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b1);
		repeat (45) send_event(CMD_TICK, 16'h0000, BID_LEFT, 1'b0);
		// full diagonal exceeds the largest threshold
		send_event(CMD_MOVE_X, 16'h8000, BID_LEFT, 1'b0);
		send_event(CMD_MOVE_Y, 16'h8000, BID_LEFT, 1'b0);
		send_event(CMD_BUTTON, 16'h0000, BID_LEFT, 1'b0);
		idle_on = 1'b1;
	endtask

	// Mostly press / move / tick / release sequences, the rest noise
	task automatic test_random(int n_phases, int per_phase);
		int goal;
		int kind;
		bit paused;
		for (int ph = 0; ph < n_phases; ph++) begin
			apply_cfg(rand_cfg());
			if (ph == n_phases - 1) idle_on = 1'b0;
			goal = counted_events + per_phase;
			paused = 1'b0;
			while (counted_events < goal) begin
				if (!paused && counted_events > goal - per_phase / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				if ($urandom_range(0, 9) < 7) begin
					send_event(CMD_BUTTON, rand_delta(), BID_LEFT, 1'b1);
					repeat ($urandom_range(1, 12)) begin
						kind = $urandom_range(0, 4);
						case (kind)
							0: send_event(CMD_MOVE_X, rand_delta(), btn_t'($urandom), 1'b0);
							1: send_event(CMD_MOVE_Y, rand_delta(), btn_t'($urandom), 1'b1);
							2: send_event(CMD_BUTTON, rand_delta(),
								($urandom_range(0, 1) == 0) ? BID_RIGHT : BID_MIDDLE,
								1'($urandom));
							default: send_event(CMD_TICK, rand_delta(), btn_t'($urandom),
								1'($urandom));
						endcase
					end
					if ($urandom_range(0, 4) != 0)
						send_event(CMD_BUTTON, rand_delta(), BID_LEFT, 1'b0);
				end else begin
					send_event(cmd_t'($urandom), rand_delta(), btn_t'($urandom),
						1'($urandom));
				end
			end
		end
	endtask

	task automatic compare_field(string label, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			errors++;
		end
	endtask

	// Report checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_report = cursor_report_t'(m_axis_tdata);
			if (pending_reports.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: unexpected report, expected none, actual %h", $time,
						m_axis_tdata);
				errors++;
			end else begin
				want_report = pending_reports.pop_front();
				compare_field("cursor_x",     16'(want_report.cx),      16'(got_report.cx));
				compare_field("cursor_y",     16'(want_report.cy),      16'(got_report.cy));
				compare_field("adjusted_x",   16'(want_report.adj_x),   16'(got_report.adj_x));
				compare_field("left_down",    16'(want_report.left),    16'(got_report.left));
				compare_field("right_down",   16'(want_report.right),   16'(got_report.right));
				compare_field("middle_down",  16'(want_report.middle),  16'(got_report.middle));
				compare_field("left_gesture", 16'(want_report.gesture), 16'(got_report.gesture));
			end
		end
	end

	// Result-side stalls
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	// Watchdog: cycles with no transfer on any channel
	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		errors         = 0;
		counted_events = 0;
		idle_on        = 1'b1;
		active_cfg     = CFG_RESET;
		cur_x          = 12'(RST_WIDTH / 2);
		cur_y          = 12'(RST_HEIGHT / 2);
		press_x        = '0;
		press_y        = '0;
		press_age      = '0;
		btn_state      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_config_edges();
		test_press_age();
		test_random(5, 230);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
